// ===== rtl/epoch_seconds_to_calendar_date_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the epoch to calendar date converter
// Shared property wrappers, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_DEFINES_SVH

// Same-cycle implication.
`define ESC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("esc assertion failed");

// Next-cycle implication.
`define ESC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("esc assertion failed");

`endif

// ===== rtl/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg
// Constants, queue entry type and month table for the date converter.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int SECS_W  = 32;
  localparam int DAYS_W  = 16;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int OUT_W   = 40;

  localparam int TOD_W  = 17;
  localparam int MREM_W = 12;
  localparam logic [TOD_W-1:0]  SECS_PER_DAY  = 17'd86400;
  localparam logic [MREM_W-1:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [SEC_W-1:0]  SECS_PER_MIN  = 6'd60;

  // Reciprocal constants: q = (x * RECIP) >> SH is exact over the full range
  // of x. Days drop the seven low zero bits of 86400 first (86400 = 675 << 7),
  // which keeps that multiply at 25 x 26 bits.
  localparam int DAY_PRE      = 7;
  localparam int DAY_RECIP_W  = 26;
  localparam int DAY_SH       = 35;
  localparam logic [DAY_RECIP_W-1:0] DAY_RECIP = 26'd50903317;   // ceil(2^35 / 675)
  localparam int HOUR_RECIP_W = 18;
  localparam int HOUR_SH      = 29;
  localparam logic [HOUR_RECIP_W-1:0] HOUR_RECIP = 18'd149131;   // ceil(2^29 / 3600)
  localparam int MIN_RECIP_W  = 13;
  localparam int MIN_SH       = 18;
  localparam logic [MIN_RECIP_W-1:0] MIN_RECIP = 13'd4370;       // ceil(2^18 / 60)

  localparam logic [YEAR_W-1:0] BASE_YEAR = 12'd1970;
  localparam logic [1:0] BASE_Y4   = 2'd2;    // 1970 mod 4
  localparam logic [6:0] BASE_Y100 = 7'd70;   // 1970 mod 100
  localparam logic [8:0] BASE_Y400 = 9'd370;  // 1970 mod 400

  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } esc_entry_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] d;
    case (m)
      4'd2:    d = leap ? 5'd29 : 5'd28;
      4'd4:    d = 5'd30;
      4'd6:    d = 5'd30;
      4'd9:    d = 5'd30;
      4'd11:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/esc_fifo.sv =====
// ----------------------------------------------------------------------------
// esc_fifo
// Two-entry queue between the splitting front end and the calendar walk.
// ----------------------------------------------------------------------------
module esc_fifo
  import esc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  esc_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output esc_entry_t pop_entry
);

  esc_entry_t  mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign full      = (count == 2'd2);
  assign empty     = (count == 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/esc_front.sv =====
// ----------------------------------------------------------------------------
// esc_front
// Accepts a seconds count and splits it into days, hour, minute and second
// with constant reciprocal multiplies, one step per cycle.
// ----------------------------------------------------------------------------
module esc_front
  import esc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [SECS_W-1:0] in_secs,
  output logic              push,
  output esc_entry_t        push_entry,
  input  logic              full
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CALC = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  localparam logic [2:0] C_DAYS = 3'd0;
  localparam logic [2:0] C_TOD  = 3'd1;
  localparam logic [2:0] C_HOUR = 3'd2;
  localparam logic [2:0] C_MREM = 3'd3;
  localparam logic [2:0] C_MIN  = 3'd4;
  localparam logic [2:0] C_SEC  = 3'd5;

  logic [1:0]        state;
  logic [2:0]        step;
  logic [SECS_W-1:0] secs;
  logic [TOD_W-1:0]  tod;
  logic [MREM_W-1:0] mrem;
  esc_entry_t        entry;

  logic [SECS_W-DAY_PRE+DAY_RECIP_W-1:0] day_prod;
  logic [DAYS_W+TOD_W-1:0]               day_secs;
  logic [TOD_W+HOUR_RECIP_W-1:0]         hour_prod;
  logic [HOUR_W+MREM_W-1:0]              hour_secs;
  logic [MREM_W+MIN_RECIP_W-1:0]         min_prod;
  logic [MIN_W+SEC_W-1:0]                min_secs;

  assign in_ready   = (state == F_IDLE);
  assign push       = (state == F_PUSH);
  assign push_entry = entry;

  assign day_prod  = secs[SECS_W-1:DAY_PRE] * DAY_RECIP;
  assign day_secs  = entry.days * SECS_PER_DAY;
  assign hour_prod = tod * HOUR_RECIP;
  assign hour_secs = entry.hour * SECS_PER_HOUR;
  assign min_prod  = mrem * MIN_RECIP;
  assign min_secs  = entry.minute * SECS_PER_MIN;

  // each remainder is below its divisor, so only its low bits are kept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      secs <= in_secs;
    end else if (state == F_CALC) begin
      case (step)
        C_DAYS:  entry.days   <= day_prod[DAY_SH+DAYS_W-1:DAY_SH];
        C_TOD:   tod          <= secs[TOD_W-1:0] - day_secs[TOD_W-1:0];
        C_HOUR:  entry.hour   <= hour_prod[HOUR_SH+HOUR_W-1:HOUR_SH];
        C_MREM:  mrem         <= tod[MREM_W-1:0] - hour_secs[MREM_W-1:0];
        C_MIN:   entry.minute <= min_prod[MIN_SH+MIN_W-1:MIN_SH];
        default: entry.second <= mrem[SEC_W-1:0] - min_secs[SEC_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= C_DAYS;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            state <= F_CALC;
            step  <= C_DAYS;
          end
        end
        F_CALC: begin
          if (step == C_SEC) begin
            state <= F_PUSH;
          end else begin
            step <= step + 3'd1;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/esc_back.sv =====
// ----------------------------------------------------------------------------
// esc_back
// Walks whole years from 1970 and then whole months off the day count,
// and holds the finished date and time in the output register.
// ----------------------------------------------------------------------------
`include "epoch_seconds_to_calendar_date_defines.svh"

module esc_back
  import esc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  esc_entry_t       pop_entry,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_data
);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_YEAR  = 2'd1;
  localparam logic [1:0] B_MONTH = 2'd2;

  logic [1:0]         state;
  logic [DAYS_W-1:0]  days;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] mon;
  logic [1:0]         y4;
  logic [6:0]         y100;
  logic [8:0]         y400;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;
  logic [SEC_W-1:0]   second;

  logic [YEAR_W-1:0]  o_year;
  logic [MONTH_W-1:0] o_month;
  logic [DAY_W-1:0]   o_day;
  logic [HOUR_W-1:0]  o_hour;
  logic [MIN_W-1:0]   o_minute;
  logic [SEC_W-1:0]   o_second;

  logic               leap;
  logic [8:0]         ylen;
  logic [DAY_W-1:0]   dim;
  logic               slot_free;
  logic               month_hit;
  logic               load_out;

  assign leap      = (y400 == 9'd0) || ((y4 == 2'd0) && (y100 != 7'd0));
  assign ylen      = leap ? 9'd366 : 9'd365;
  assign dim       = month_days(mon, leap);
  assign slot_free = !out_valid || out_ready;
  assign month_hit = (days < {{(DAYS_W-DAY_W){1'b0}}, dim});
  assign load_out  = (state == B_MONTH) && month_hit && slot_free;
  assign pop       = (state == B_IDLE) && !empty;

  assign out_data = {2'b00, o_second, o_minute, o_hour, o_day, o_month, o_year};

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!empty) begin
          days   <= pop_entry.days;
          hour   <= pop_entry.hour;
          minute <= pop_entry.minute;
          second <= pop_entry.second;
          year   <= BASE_YEAR;
          y4     <= BASE_Y4;
          y100   <= BASE_Y100;
          y400   <= BASE_Y400;
          mon    <= 4'd1;
        end
      end
      B_YEAR: begin
        if (days >= {{(DAYS_W-9){1'b0}}, ylen}) begin
          days <= days - {{(DAYS_W-9){1'b0}}, ylen};
          year <= year + 12'd1;
          y4   <= y4 + 2'd1;
          y100 <= (y100 == 7'd99) ? 7'd0 : y100 + 7'd1;
          y400 <= (y400 == 9'd399) ? 9'd0 : y400 + 9'd1;
        end
      end
      B_MONTH: begin
        if (!month_hit) begin
          days <= days - {{(DAYS_W-DAY_W){1'b0}}, dim};
          mon  <= mon + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_year   <= year;
      o_month  <= mon;
      o_day    <= days[DAY_W-1:0] + 5'd1;
      o_hour   <= hour;
      o_minute <= minute;
      o_second <= second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!empty) begin
            state <= B_YEAR;
          end
        end
        B_YEAR: begin
          if (days < {{(DAYS_W-9){1'b0}}, ylen}) begin
            state <= B_MONTH;
          end
        end
        B_MONTH: begin
          // hold the finished walk until the output register frees up
          if (load_out) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `ESC_ASSERT_NOW(a_month_range, state == B_MONTH, mon >= 4'd1 && mon <= 4'd12)
  `ESC_ASSERT_NOW(a_month_days_left, state == B_MONTH, days < 16'd366)
  `ESC_ASSERT_NOW(a_year_range, state == B_YEAR, year >= 12'd1970 && year <= 12'd2106)
  `ESC_ASSERT_NEXT(a_load_shows, load_out, out_valid && o_day != 5'd0)

endmodule

// ===== rtl/epoch_seconds_to_calendar_date.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date
// Converts an unsigned seconds count since 1970-01-01 00:00:00 into the
// Gregorian year, month, day and the hour, minute and second of the day.
//
// Input stream s_axis carries one 32-bit count per request; output stream
// m_axis returns exactly one date per request, in order.
// The front end splits the count with constant reciprocal multiplies, one
// step per cycle (days, time of day, hour, minute remainder, minute, second),
// and takes the next request only once it has written the queue entry.
// The back end walks one year per cycle from 1970, then one month per
// cycle, and pops the next entry only after loading the output register;
// the year walk sets the sustained rate. The wait for a result grows with
// the year and month of its date.
// A two-entry queue between the two lets the front split the next request
// while the back walks the current one.
// When m_axis_tready is low the result holds in the output register, the
// back end stalls once it has the next date, and the queue then fills up
// and drops s_axis_tready. rst clears all control state; no pass follows.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_date
  import esc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [SECS_W-1:0] s_axis_tdata,  // [31:0] epoch_seconds
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [11:0] year, [15:12] month, [20:16] day, [25:21] hour,
  // [31:26] minute, [37:32] second, [39:38] zero
  output logic [OUT_W-1:0]  m_axis_tdata
);

  logic       push;
  esc_entry_t push_entry;
  logic       full;
  logic       pop;
  logic       empty;
  esc_entry_t pop_entry;

  esc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_secs    (s_axis_tdata),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  esc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .pop_entry  (pop_entry)
  );

  esc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// ===== bench/epoch_seconds_to_calendar_date_test.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date_test
// Feeds seconds counts into the converter and checks every returned date
// field by field against a date taken from the table or computed in the
// bench. A short table of fixed counts (epoch start, last count, leap days,
// century years) comes first, then random counts with random idle on both streams.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_date_test;
  import esc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_COUNT = 600;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [SEC_W-1:0]   second;
    logic [MIN_W-1:0]   minute;
    logic [HOUR_W-1:0]  hour;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  typedef struct packed {
    logic [SECS_W-1:0] secs;
    logic              known;
    date_t             date;
  } stim_row_t;

  localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  localparam int ROWS = 18;
  localparam stim_row_t DIRECTED [ROWS] = '{
    '{secs: 32'd0, known: 1'b1,
      date: '{year: 12'd1970, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0, second: 6'd0}},
    '{secs: 32'hFFFF_FFFF, known: 1'b1,
      date: '{year: 12'd2106, month: 4'd2, day: 5'd7, hour: 5'd6, minute: 6'd28, second: 6'd15}},
    '{secs: 32'd86399, known: 1'b1,
      date: '{year: 12'd1970, month: 4'd1, day: 5'd1, hour: 5'd23, minute: 6'd59,
              second: 6'd59}},
    '{secs: 32'd86400, known: 1'b1,
      date: '{year: 12'd1970, month: 4'd1, day: 5'd2, hour: 5'd0, minute: 6'd0, second: 6'd0}},
    '{secs: 32'd31535999, known: 1'b1,
      date: '{year: 12'd1970, month: 4'd12, day: 5'd31, hour: 5'd23, minute: 6'd59,
              second: 6'd59}},
    '{secs: 32'd31536000, known: 1'b1,
      date: '{year: 12'd1971, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0, second: 6'd0}},
    '{secs: 32'd68169600,   known: 1'b0, date: '0},  // first leap day after the epoch
    '{secs: 32'd68255999,   known: 1'b0, date: '0},
    '{secs: 32'd946684799,  known: 1'b0, date: '0},  // last second of 1999
    '{secs: 32'd951782400,  known: 1'b0, date: '0},  // leap day of a year divisible by 400
    '{secs: 32'd951868800,  known: 1'b0, date: '0},
    '{secs: 32'd4107455999, known: 1'b0, date: '0},  // century year without a leap day
    '{secs: 32'd4107542400, known: 1'b0, date: '0},
    '{secs: 32'h7FFF_FFFF,  known: 1'b0, date: '0},
    '{secs: 32'h8000_0000,  known: 1'b0, date: '0},
    '{secs: 32'hAAAA_AAAA,  known: 1'b0, date: '0},
    '{secs: 32'h5555_5555,  known: 1'b0, date: '0},
    '{secs: 32'd1234567890, known: 1'b0, date: '0}
  };

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [SECS_W-1:0] s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;

  date_t expected_dates [$];
  int    mismatches;
  int    stall_cycles;
  int    send_run;
  bit    send_eager;
  int    recv_run;
  bit    recv_eager;

  epoch_seconds_to_calendar_date uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic bit is_leap(input int unsigned y);
    return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
  endfunction

  function automatic date_t calendar_of(input logic [SECS_W-1:0] secs);
    date_t       d;
    int unsigned days;
    int unsigned tod;
    int unsigned yr;
    int unsigned ylen;
    int unsigned mlen;
    int unsigned mo;
    days = secs / 86400;
    tod  = secs % 86400;
    yr   = 1970;
    ylen = is_leap(yr) ? 366 : 365;
    while (days >= ylen) begin
      days -= ylen;
      yr++;
      ylen = is_leap(yr) ? 366 : 365;
    end
    mo = 1;
    mlen = MONTH_LEN[0];
    while (days >= mlen && mo < 12) begin
      days -= mlen;
      mo++;
      mlen = (mo == 2 && is_leap(yr)) ? 29 : MONTH_LEN[mo-1];
    end
    d.year   = yr[YEAR_W-1:0];
    d.month  = mo[MONTH_W-1:0];
    d.day    = 5'(days + 1);
    d.hour   = 5'(tod / 3600);
    d.minute = 6'((tod % 3600) / 60);
    d.second = 6'(tod % 60);
    return d;
  endfunction

  // Idle runs: most stretches idle at random, some stretches not at all.
  function automatic int draw_gap(inout int run_left, inout bit eager);
    if (run_left == 0) begin
      run_left = $urandom_range(10, 60);
      eager    = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return eager ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [SECS_W-1:0] random_secs();
    longint v;
    case ($urandom_range(0, 3))
      0, 1: v = $urandom;
      // land on either side of a midnight
      2: begin
        v = longint'($urandom_range(0, 49710)) * 86400;
        if ($urandom_range(0, 1) == 1) v += 86399;
        if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
      end
      default: v = $urandom_range(0, 200_000_000);
    endcase
    return v[SECS_W-1:0];
  endfunction

  // Offer one request and wait until it is taken.
  task automatic send_count(input logic [SECS_W-1:0] secs, input bit known,
                            input date_t date);
    int gap;
    gap = draw_gap(send_run, send_eager);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= secs;
    do @(posedge clk); while (!s_axis_tready);
    expected_dates.push_back(known ? date : calendar_of(secs));
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    mismatches    = 0;
    send_run      = 0;
    send_eager    = 1'b0;
    recv_run      = 0;
    recv_eager    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);
    for (int i = 0; i < ROWS; i++) begin
      send_count(DIRECTED[i].secs, DIRECTED[i].known, DIRECTED[i].date);
    end
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      send_count(random_secs(), 1'b0, '0);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[epoch_seconds_to_calendar_date] OK");
    end else begin
      $display("[epoch_seconds_to_calendar_date] ERROR");
    end
    $finish;
  end

  // Result side: hold off for a drawn number of cycles per result.
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = draw_gap(recv_run, recv_eager);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    date_t got;
    date_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(date_t)-1:0];
      if (expected_dates.size() == 0) begin
        $error("unexpected date %0d-%0d-%0d %0d:%0d:%0d", got.year, got.month, got.day,
               got.hour, got.minute, got.second);
        mismatches++;
      end else begin
        want = expected_dates.pop_front();
        check_field("year",   want.year,   got.year);
        check_field("month",  want.month,  got.month);
        check_field("day",    want.day,    got.day);
        check_field("hour",   want.hour,   got.hour);
        check_field("minute", want.minute, got.minute);
        check_field("second", want.second, got.second);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[epoch_seconds_to_calendar_date] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/esc_pkg.sv
rtl/esc_fifo.sv
rtl/esc_front.sv
rtl/esc_back.sv
rtl/epoch_seconds_to_calendar_date.sv
bench/epoch_seconds_to_calendar_date_test.sv
